// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VMD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel map check failed");

// next-cycle implication, disabled while in reset
`define VMD_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel map check failed");

`endif

// ===== hw/rtl/vmd_pkg.sv =====
// ----------------------------------------------------------------------------
// vmd_pkg
// shared types and constants of the voxel map dilation unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmd_pkg;

  localparam int DEF_MAX_X = 64;
  localparam int DEF_MAX_Y = 64;
  localparam int DEF_MAX_Z = 64;

  localparam int VOXEL_W    = 8;
  localparam int POS_W      = 6;
  localparam int REQ_W      = 2;
  localparam int PASS_W     = 4;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // request kinds carried on s_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_INFLATE = 2'd1,
    REQ_READ    = 2'd2
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASS_COUNT = 2'd0,
    CFG_SIZE_X     = 2'd1,
    CFG_SIZE_Y     = 2'd2,
    CFG_SIZE_Z     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_ACCESS,
    ST_RESP,
    ST_SETUP,
    ST_DILATE,
    ST_COPY,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/voxel_map_dilation_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_map_dilation_unit
// 3d grid of signed 8-bit occupancy voxels with 3x3x3 max dilation
// ----------------------------------------------------------------------------
// The unit holds a MAX_X x MAX_Y x MAX_Z grid of signed voxels in a voxel
// memory and a scratch memory of the same size, addressed as
// (x * MAX_Y + y) * MAX_Z + z. Requests arrive on the s_ stream with the kind
// on s_tuser: a write stores a voxel, a read returns it as one m_ transaction,
// an inflate runs pass_count dilation passes over the configured extent.
// Items are taken one at a time: a write runs address and access states, a
// read adds a response state held while an earlier result waits on m_tvalid,
// an unused request kind leaves the unit idle. An inflate runs, per pass, a
// dilation sweep over the (ex-2)*(ey-2)*(ez-2) interior voxels, ex..ez the
// sizes clipped to MAX_*, reading 27 neighbours each on the single voxel read
// port, then a copy-back sweep reading scratch one voxel at a time. Sizes
// below 3 or a pass count of zero make an inflate a no-op. Voxels never
// written since reset read as undefined; coordinates past MAX_* are ignored
// on write and read back as zero. The user must write configuration only
// while no item is in flight; the unit does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_map_dilation_unit import vmd_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // pos_x[5:0], pos_y[11:6], pos_z[17:12], voxel_in[25:18], zero[31:26]
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  wire logic [REQ_W-1:0]      s_tuser,
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // voxel_out[7:0]
  output logic      [M_TDATA_W-1:0]  m_tdata,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int STRIDE_Z   = MAX_Z;
  localparam int STRIDE_X   = MAX_Y * MAX_Z;
  localparam int DEPTH      = MAX_X * STRIDE_X;
  localparam int AW         = $clog2(DEPTH);
  // nrow step when the neighbour x offset advances (undoes two y steps)
  localparam int STEP_X     = STRIDE_X - 2 * STRIDE_Z;
  // center of a neighbourhood relative to its low corner
  localparam int CENTER_OFF = STRIDE_X + STRIDE_Z + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [PASS_W-1:0] pass_count;
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= '0;
      size_x     <= SIZE_RESET;
      size_y     <= SIZE_RESET;
      size_z     <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PASS_COUNT: pass_count <= cfg_wdata[PASS_W-1:0];
        CFG_SIZE_X:     size_x     <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_Y:     size_y     <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_Z:     size_z     <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // extents clipped to storage; sweep limits are extent - 3 (0-based corner)
  logic [8:0]        ext_x_w, ext_y_w, ext_z_w;
  logic [SIZE_W-1:0] ext_x, ext_y, ext_z;
  logic [SIZE_W-1:0] lim_x, lim_y, lim_z;
  logic              ext_small;

  always_comb begin
    ext_x_w   = (9'(size_x) > 9'(MAX_X)) ? 9'(MAX_X) : 9'(size_x);
    ext_y_w   = (9'(size_y) > 9'(MAX_Y)) ? 9'(MAX_Y) : 9'(size_y);
    ext_z_w   = (9'(size_z) > 9'(MAX_Z)) ? 9'(MAX_Z) : 9'(size_z);
    ext_x     = ext_x_w[SIZE_W-1:0];
    ext_y     = ext_y_w[SIZE_W-1:0];
    ext_z     = ext_z_w[SIZE_W-1:0];
    ext_small = (ext_x < 7'd3) || (ext_y < 7'd3) || (ext_z < 7'd3);
    lim_x     = ext_x - 7'd3;
    lim_y     = ext_y - 7'd3;
    lim_z     = ext_z - 7'd3;
  end

  // --------------------------------------------------------------------------
  // request unpacking and capture
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]   in_x, in_y, in_z;
  logic [VOXEL_W-1:0] in_voxel;
  logic               s_accept;

  assign in_x     = s_tdata[POS_W-1:0];
  assign in_y     = s_tdata[2*POS_W-1:POS_W];
  assign in_z     = s_tdata[3*POS_W-1:2*POS_W];
  assign in_voxel = s_tdata[3*POS_W+VOXEL_W-1:3*POS_W];
  assign s_accept = s_tvalid && s_tready;

  logic [REQ_W-1:0]   req_q;
  logic               inside_q;
  logic [AW-1:0]      prod_x;
  logic [AW-1:0]      prod_y;
  logic [POS_W-1:0]   z_q;
  logic [VOXEL_W-1:0] vin_q;
  logic [AW-1:0]      req_addr;

  state_t state, state_next;

  // address is built in registered steps: constant products, then the sum
  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_q    <= s_tuser;
      inside_q <= (9'(in_x) < 9'(MAX_X)) && (9'(in_y) < 9'(MAX_Y)) &&
                  (9'(in_z) < 9'(MAX_Z));
      prod_x   <= AW'(in_x) * AW'(STRIDE_X);
      prod_y   <= AW'(in_y) * AW'(STRIDE_Z);
      z_q      <= in_z;
      vin_q    <= in_voxel;
    end
    if (state == ST_ADDR) begin
      req_addr <= prod_x + prod_y + AW'(z_q);
    end
  end

  // --------------------------------------------------------------------------
  // control outputs per state
  // --------------------------------------------------------------------------
  logic dil_issue;   // one neighbour read per cycle
  logic cp_issue;    // one scratch read per cycle
  logic req_wr;
  logic req_rd;
  logic resp_load;

  always_comb begin
    s_tready  = 1'b0;
    dil_issue = 1'b0;
    cp_issue  = 1'b0;
    req_wr    = 1'b0;
    req_rd    = 1'b0;
    resp_load = 1'b0;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_ACCESS: begin
        req_wr = (req_q == REQ_WRITE) && inside_q;
        req_rd = (req_q == REQ_READ);
      end
      ST_RESP:   resp_load = !m_tvalid || m_tready;
      ST_DILATE: dil_issue = 1'b1;
      ST_COPY:   cp_issue  = 1'b1;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // sweep walker: corner (ii,jj,kk) of each neighbourhood, offsets (dx,dy,dz)
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] ii, jj, kk;
  logic [1:0]        dx, dy, dz;
  logic [AW-1:0]     xbase;    // ii * STRIDE_X
  logic [AW-1:0]     rowbase;  // xbase + jj * STRIDE_Z
  logic [AW-1:0]     nrow;     // row of the current neighbour, z = 0
  logic [PASS_W-1:0] pass_left;
  logic              drain_to_copy;

  logic          d_first, d_last;
  logic          vox_adv;
  logic          k_wrap, j_wrap, i_wrap;
  logic          sweep_done;
  logic [AW-1:0] dil_addr;
  logic [AW-1:0] center_addr;

  always_comb begin
    d_first     = (dx == 2'd0) && (dy == 2'd0) && (dz == 2'd0);
    d_last      = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
    vox_adv     = (dil_issue && d_last) || cp_issue;
    k_wrap      = (kk == lim_z);
    j_wrap      = (jj == lim_y);
    i_wrap      = (ii == lim_x);
    sweep_done  = vox_adv && k_wrap && j_wrap && i_wrap;
    dil_addr    = nrow + AW'(kk) + AW'(dz);
    center_addr = rowbase + AW'(kk) + AW'(CENTER_OFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ii            <= '0;
      jj            <= '0;
      kk            <= '0;
      dx            <= '0;
      dy            <= '0;
      dz            <= '0;
      xbase         <= '0;
      rowbase       <= '0;
      nrow          <= '0;
      pass_left     <= '0;
      drain_to_copy <= 1'b0;
    end else begin
      if (state == ST_SETUP) begin
        ii            <= '0;
        jj            <= '0;
        kk            <= '0;
        dx            <= '0;
        dy            <= '0;
        dz            <= '0;
        xbase         <= '0;
        rowbase       <= '0;
        nrow          <= '0;
        pass_left     <= pass_count;
        drain_to_copy <= 1'b0;
      end
      // neighbour offsets, z fastest
      if (dil_issue) begin
        if (dz != 2'd2) begin
          dz <= dz + 2'd1;
        end else begin
          dz <= 2'd0;
          if (dy != 2'd2) begin
            dy   <= dy + 2'd1;
            nrow <= nrow + AW'(STRIDE_Z);
          end else begin
            dy <= 2'd0;
            if (dx != 2'd2) begin
              dx   <= dx + 2'd1;
              nrow <= nrow + AW'(STEP_X);
            end else begin
              dx <= 2'd0;
            end
          end
        end
      end
      // next neighbourhood corner, wraps to the origin at the end of a sweep
      if (vox_adv) begin
        if (!k_wrap) begin
          kk   <= kk + 7'd1;
          nrow <= rowbase;
        end else begin
          kk <= '0;
          if (!j_wrap) begin
            jj      <= jj + 7'd1;
            rowbase <= rowbase + AW'(STRIDE_Z);
            nrow    <= rowbase + AW'(STRIDE_Z);
          end else begin
            jj <= '0;
            if (!i_wrap) begin
              ii      <= ii + 7'd1;
              xbase   <= xbase + AW'(STRIDE_X);
              rowbase <= xbase + AW'(STRIDE_X);
              nrow    <= xbase + AW'(STRIDE_X);
            end else begin
              ii      <= '0;
              xbase   <= '0;
              rowbase <= '0;
              nrow    <= '0;
            end
          end
        end
      end
      if ((state == ST_DILATE) && sweep_done) begin
        drain_to_copy <= 1'b1;
      end
      if ((state == ST_COPY) && sweep_done) begin
        drain_to_copy <= 1'b0;
        pass_left     <= pass_left - 4'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // state register and next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_tuser inside {REQ_WRITE, REQ_READ}) begin
            state_next = ST_ADDR;
          end else if (s_tuser == REQ_INFLATE) begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_ADDR:   state_next = ST_ACCESS;
      ST_ACCESS: state_next = (req_q == REQ_READ) ? ST_RESP : ST_IDLE;
      ST_RESP:   state_next = resp_load ? ST_IDLE : ST_RESP;
      ST_SETUP: begin
        state_next = ((pass_count == '0) || ext_small) ? ST_IDLE : ST_DILATE;
      end
      ST_DILATE: state_next = sweep_done ? ST_DRAIN : ST_DILATE;
      ST_COPY:   state_next = sweep_done ? ST_DRAIN : ST_COPY;
      // lets the last write of a sweep land before the other memory is read
      ST_DRAIN: begin
        if (drain_to_copy) begin
          state_next = ST_COPY;
        end else begin
          state_next = (pass_left == '0) ? ST_IDLE : ST_DILATE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // memories and read pipeline
  // --------------------------------------------------------------------------
  logic               vox_we, vox_re, scr_we, scr_re;
  logic [AW-1:0]      vox_waddr, vox_raddr, scr_waddr, scr_raddr;
  logic [VOXEL_W-1:0] vox_wdata, vox_rdata, scr_wdata, scr_rdata;

  logic                      rd_v, rd_first, rd_last;
  logic [AW-1:0]             ctr_d;
  logic                      cp_v;
  logic [AW-1:0]             cp_addr;
  logic signed [VOXEL_W-1:0] best;
  logic signed [VOXEL_W-1:0] vox_sdata;
  logic signed [VOXEL_W-1:0] cur_max;

  always_comb begin
    vox_sdata = $signed(vox_rdata);
    if (rd_first) begin
      cur_max = vox_sdata;
    end else begin
      cur_max = (vox_sdata > best) ? vox_sdata : best;
    end
  end

  // copy-back never overlaps a request write: requests run only when idle
  assign vox_re    = dil_issue || req_rd;
  assign vox_raddr = dil_issue ? dil_addr : req_addr;
  assign vox_we    = cp_v || req_wr;
  assign vox_waddr = cp_v ? cp_addr : req_addr;
  assign vox_wdata = cp_v ? scr_rdata : vin_q;

  assign scr_re    = cp_issue;
  assign scr_raddr = center_addr;
  assign scr_we    = rd_v && rd_last;
  assign scr_waddr = ctr_d;
  assign scr_wdata = cur_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      cp_v <= 1'b0;
    end else begin
      rd_v <= dil_issue;
      cp_v <= cp_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= d_first;
    rd_last  <= d_last;
    ctr_d    <= center_addr;
    cp_addr  <= center_addr;
    if (rd_v) begin
      best <= cur_max;
    end
  end

  vmd_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (VOXEL_W)
  ) u_voxel_ram (
    .clk   (clk),
    .we    (vox_we),
    .waddr (vox_waddr),
    .wdata (vox_wdata),
    .re    (vox_re),
    .raddr (vox_raddr),
    .rdata (vox_rdata)
  );

  vmd_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (VOXEL_W)
  ) u_scratch_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .re    (scr_re),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (resp_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // reads past storage return zero
  always_ff @(posedge clk) begin
    if (resp_load) begin
      m_tdata <= inside_q ? vox_rdata : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vmd_ram.sv =====
// ----------------------------------------------------------------------------
// vmd_ram
// simple dual-port voxel memory, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmd_ram import vmd_pkg::*; #(
  parameter int DEPTH = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = VOXEL_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vmd_checker.sv =====
// ----------------------------------------------------------------------------
// vmd_checker
// port-level checks of the voxel map dilation unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vmd_checker import vmd_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [REQ_W-1:0]     s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  logic acc;
  logic acc_known;
  logic acc_no_result;

  assign acc           = s_tvalid && s_tready;
  assign acc_known     = acc && ((s_tuser == REQ_WRITE) || (s_tuser == REQ_INFLATE) ||
                                 (s_tuser == REQ_READ));
  assign acc_no_result = acc && ((s_tuser == REQ_WRITE) || (s_tuser == REQ_INFLATE));

  // a stalled result holds
  `VMD_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item at a time: a real request keeps the input closed next cycle
  `VMD_ASSERT_NXT(a_one_in_flight, clk, rst, acc_known, !s_tready)

  // writes and inflates never produce a result
  `VMD_ASSERT_NXT(a_no_spurious_out, clk, rst, acc_no_result && !m_tvalid, !m_tvalid)

  // a result appears only as the read finishes and the input reopens
  `VMD_ASSERT_IMP(a_out_at_finish, clk, rst, $rose(m_tvalid), s_tready)

endmodule

bind voxel_map_dilation_unit vmd_checker u_vmd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/voxel_map_dilation_unit_test.sv =====
// ----------------------------------------------------------------------------
// voxel_map_dilation_unit_test
// self-checking bench for the voxel map dilation unit: a directed table, a
// backpressure run, then register phases that fill the active box with random
// voxels when a dilation will read it and mix writes, reads, inflates and
// unused requests, every read compared against a behavioral grid with its own 3x3x3 max dilation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_map_dilation_unit_test;
  import vmd_pkg::*;

  localparam int GRID_CELLS   = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_TICKS = 16;
  localparam int HOLD_TICKS   = 300;
  localparam int MAX_INFLATES = 3;
  // worst inflate in any phase has 64 interior voxels and 4 passes, at most
  // 3 per phase over a dozen phases, plus ~2k requests at their longest gaps
  // and stalls; the limit covers that several times over
  localparam int CYCLE_LIMIT  = 2_000_000;

  // request code with no function in the unit
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] x, y, z;
    logic signed [7:0] voxel;
    bit               typed;
    logic signed [7:0] want;
  } stim_row_t;

  typedef struct {
    logic [POS_W-1:0] x, y, z;
    logic signed [7:0] voxel;
  } read_expect_t;

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [REQ_W-1:0]      s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PASS_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  voxel_map_dilation_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    // pos_x[5:0], pos_y[11:6], pos_z[17:12], voxel_in[25:18], zero[31:26]
    .s_tdata   (s_tdata),
    // req_type[1:0]
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    // voxel_out[7:0]
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // behavioral grid: voxel store, dilation scratch and register copies
  // --------------------------------------------------------------------------
  logic signed [7:0] grid    [GRID_CELLS];
  logic signed [7:0] scratch [GRID_CELLS];
  bit                written [GRID_CELLS];
  int                written_cells [$];   // every cell index written since reset

  logic [PASS_W-1:0] pass_count = '0;
  logic [SIZE_W-1:0] size_x = SIZE_RESET;
  logic [SIZE_W-1:0] size_y = SIZE_RESET;
  logic [SIZE_W-1:0] size_z = SIZE_RESET;

  read_expect_t pending_reads [$];

  // bookkeeping
  bit no_gaps       = 1'b0;   // both sides run without idle cycles
  int rx_hold_left  = 0;      // long receiver hold-off, counted down by the receiver
  int rx_stall_left = 0;
  int mismatch_count = 0;
  int reads_checked  = 0;
  int requests_sent  = 0;
  int inflates_sent  = 0;
  int phases_run     = 0;
  int cycle_count    = 0;

  function automatic int cell_of(input int x, input int y, input int z);
    return (x * DEF_MAX_Y + y) * DEF_MAX_Z + z;
  endfunction

  // size register clipped to the storage
  function automatic int extent(input logic [SIZE_W-1:0] s, input int limit);
    return (int'(s) > limit) ? limit : int'(s);
  endfunction

  // grayscale 3x3x3 max over the interior of the active box, pass by pass
  function automatic void inflate_grid();
    int ex, ey, ez;
    logic signed [7:0] best;
    ex = extent(size_x, DEF_MAX_X);
    ey = extent(size_y, DEF_MAX_Y);
    ez = extent(size_z, DEF_MAX_Z);
    if (ex < 3 || ey < 3 || ez < 3) return;
    for (int n = 0; n < int'(pass_count); n++) begin
      for (int i = 1; i < ex - 1; i++)
        for (int j = 1; j < ey - 1; j++)
          for (int k = 1; k < ez - 1; k++) begin
            best = grid[cell_of(i, j, k)];
            for (int dx = -1; dx <= 1; dx++)
              for (int dy = -1; dy <= 1; dy++)
                for (int dz = -1; dz <= 1; dz++)
                  if (grid[cell_of(i + dx, j + dy, k + dz)] > best)
                    best = grid[cell_of(i + dx, j + dy, k + dz)];
            scratch[cell_of(i, j, k)] = best;
          end
      for (int i = 1; i < ex - 1; i++)
        for (int j = 1; j < ey - 1; j++)
          for (int k = 1; k < ez - 1; k++)
            grid[cell_of(i, j, k)] = scratch[cell_of(i, j, k)];
    end
  endfunction

  // updates the grid for one accepted request, returns the voxel a read sees
  function automatic logic signed [7:0] predict_request(
    input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] x, y, z,
    input logic signed [7:0] v);
    int idx;
    idx = cell_of(int'(x), int'(y), int'(z));
    if (kind == REQ_WRITE) begin
      grid[idx] = v;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_cells.push_back(idx);
      end
    end else if (kind == REQ_INFLATE) begin
      inflate_grid();
    end
    return grid[idx];
  endfunction

  function automatic logic signed [7:0] random_voxel();
    case ($urandom_range(0, 15))
      0:       return 8'sh7f;
      1:       return 8'sh80;
      2:       return 8'sh00;
      3:       return 8'shff;
      default: return 8'($urandom);
    endcase
  endfunction

  // only cells written since reset may be read
  function automatic void pick_written_cell(output logic [POS_W-1:0] x, y, z);
    int idx;
    idx = written_cells[$urandom_range(0, written_cells.size() - 1)];
    x = POS_W'(idx / (DEF_MAX_Y * DEF_MAX_Z));
    y = POS_W'((idx / DEF_MAX_Z) % DEF_MAX_Y);
    z = POS_W'(idx % DEF_MAX_Z);
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endfunction

  // --------------------------------------------------------------------------
  // request side: one transaction per call, random gap in front
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [POS_W-1:0] x, y, z,
                              input logic signed [7:0] v,
                              input bit typed = 1'b0,
                              input logic signed [7:0] want = 8'sh00);
    int gap;
    logic signed [7:0] seen;
    read_expect_t e;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    // valid stays high through back-to-back transactions
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'b0, v, z, y, x};
    do @(posedge clk); while (!s_tready);
    // transaction taken at this edge
    seen = predict_request(kind, x, y, z, v);
    requests_sent++;
    if (kind == REQ_INFLATE) inflates_sent++;
    if (kind == REQ_READ) begin
      e.x = x;
      e.y = y;
      e.z = z;
      e.voxel = typed ? want : seen;
      pending_reads.push_back(e);
    end
  endtask

  // valid drops at the edge of the last transaction, then the results drain
  task automatic wait_reads_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // one register per cycle, enable dropped after the last
  task automatic set_config(input int passes, input int sx, input int sy,
                            input int sz);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PASS_COUNT;
    cfg_wdata <= CFG_DATA_W'(passes);
    @(posedge clk);
    cfg_index <= CFG_SIZE_X;
    cfg_wdata <= CFG_DATA_W'(sx);
    @(posedge clk);
    cfg_index <= CFG_SIZE_Y;
    cfg_wdata <= CFG_DATA_W'(sy);
    @(posedge clk);
    cfg_index <= CFG_SIZE_Z;
    cfg_wdata <= CFG_DATA_W'(sz);
    @(posedge clk);
    cfg_we <= 1'b0;
    pass_count = passes[PASS_W-1:0];
    size_x = sx[SIZE_W-1:0];
    size_y = sy[SIZE_W-1:0];
    size_z = sz[SIZE_W-1:0];
  endtask

  // one register setting: settle, configure, fill the box when a dilation
  // will read it, then a random mix of requests ending in a read
  task automatic run_phase(input int passes, input int sx, input int sy,
                           input int sz, input int n_random, input bit steady);
    int ex, ey, ez, r, inflates;
    bit filled;
    logic [POS_W-1:0] x, y, z;
    // the last read has come back, so the unit is already idle; settle anyway
    wait_reads_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    set_config(passes, sx, sy, sz);
    no_gaps  = steady;
    ex = extent(size_x, DEF_MAX_X);
    ey = extent(size_y, DEF_MAX_Y);
    ez = extent(size_z, DEF_MAX_Z);
    filled   = 1'b0;
    inflates = 0;
    if (ex >= 3 && ey >= 3 && ez >= 3 && pass_count != 0) begin
      // dilation reads the whole box, borders included
      for (int i = 0; i < ex; i++)
        for (int j = 0; j < ey; j++)
          for (int k = 0; k < ez; k++)
            send_request(REQ_WRITE, POS_W'(i), POS_W'(j), POS_W'(k), random_voxel());
      filled = 1'b1;
      send_request(REQ_INFLATE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   8'($urandom));
      inflates++;
    end
    for (int n = 0; n < n_random; n++) begin
      r = $urandom_range(0, 99);
      if (r >= 80 && r < 84 && inflates < MAX_INFLATES) begin
        // position and voxel fields carry noise, the unit ignores them
        send_request(REQ_INFLATE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     8'($urandom));
        inflates++;
      end else if (r >= 84 && r < 90) begin
        send_request(REQ_UNUSED, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     8'($urandom));
      end else if (r >= 40 && r < 80) begin
        if ($urandom_range(0, 1)) begin
          x = POS_W'($urandom_range(0, ex - 1));
          y = POS_W'($urandom_range(0, ey - 1));
          z = POS_W'($urandom_range(0, ez - 1));
        end else begin
          x = POS_W'($urandom);
          y = POS_W'($urandom);
          z = POS_W'($urandom);
        end
        send_request(REQ_WRITE, x, y, z, random_voxel());
      end else begin
        if (filled && $urandom_range(0, 1)) begin
          x = POS_W'($urandom_range(0, ex - 1));
          y = POS_W'($urandom_range(0, ey - 1));
          z = POS_W'($urandom_range(0, ez - 1));
        end else begin
          pick_written_cell(x, y, z);
        end
        send_request(REQ_READ, x, y, z, 8'($urandom));
      end
    end
    pick_written_cell(x, y, z);
    send_request(REQ_READ, x, y, z, 8'($urandom));
    phases_run++;
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall after each transaction, long hold on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) rx_stall_left = no_gaps ? 0 : $urandom_range(0, 5);
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // every result transaction against the oldest outstanding read
  always @(posedge clk) begin : result_check
    read_expect_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reads.size() == 0) begin
        note_mismatch($sformatf("result %0d with no read outstanding",
                                $signed(m_tdata)));
      end else begin
        e = pending_reads.pop_front();
        reads_checked++;
        if (m_tdata !== e.voxel)
          note_mismatch($sformatf("voxel (%0d,%0d,%0d) expected %0d got %0d",
                                  e.x, e.y, e.z, e.voxel, $signed(m_tdata)));
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
               pending_reads.size());
      $display("voxel_map_dilation_unit_test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [24];

  initial begin
    logic [POS_W-1:0] x, y, z;

    // reset registers: no passes, full extent, so an inflate is a no-op
    directed_rows = '{
      '{REQ_WRITE,   6'd0,  6'd0,  6'd0,  8'sh7f, 1'b0, 8'sh00},  // corner extremes
      '{REQ_WRITE,   6'd63, 6'd63, 6'd63, 8'sh80, 1'b0, 8'sh00},
      '{REQ_WRITE,   6'd42, 6'd21, 6'd63, 8'sh00, 1'b0, 8'sh00},  // alternating bits
      '{REQ_WRITE,   6'd21, 6'd42, 6'd0,  8'shff, 1'b0, 8'sh00},
      '{REQ_READ,    6'd0,  6'd0,  6'd0,  8'sh00, 1'b1, 8'sh7f},
      '{REQ_READ,    6'd63, 6'd63, 6'd63, 8'sh00, 1'b1, 8'sh80},
      '{REQ_READ,    6'd42, 6'd21, 6'd63, 8'sh00, 1'b1, 8'sh00},
      '{REQ_READ,    6'd21, 6'd42, 6'd0,  8'sh00, 1'b1, 8'shff},
      '{REQ_WRITE,   6'd0,  6'd0,  6'd0,  8'sh01, 1'b0, 8'sh00},  // overwrite
      '{REQ_READ,    6'd0,  6'd0,  6'd0,  8'sh00, 1'b1, 8'sh01},
      '{REQ_INFLATE, 6'd0,  6'd0,  6'd0,  8'sh00, 1'b0, 8'sh00},  // zero passes
      '{REQ_READ,    6'd63, 6'd63, 6'd63, 8'sh00, 1'b1, 8'sh80},
      '{REQ_UNUSED,  6'd63, 6'd63, 6'd63, 8'sh7f, 1'b0, 8'sh00},  // must not write
      '{REQ_READ,    6'd63, 6'd63, 6'd63, 8'sh00, 1'b1, 8'sh80},
      '{REQ_WRITE,   6'd63, 6'd0,  6'd0,  8'sh55, 1'b0, 8'sh00},
      '{REQ_READ,    6'd63, 6'd0,  6'd0,  8'sh00, 1'b1, 8'sh55},
      '{REQ_WRITE,   6'd0,  6'd63, 6'd0,  8'shaa, 1'b0, 8'sh00},
      '{REQ_READ,    6'd0,  6'd63, 6'd0,  8'sh00, 1'b1, 8'shaa},
      '{REQ_WRITE,   6'd0,  6'd0,  6'd63, 8'sh40, 1'b0, 8'sh00},
      '{REQ_UNUSED,  6'd0,  6'd0,  6'd63, 8'sh00, 1'b0, 8'sh00},
      '{REQ_READ,    6'd0,  6'd0,  6'd63, 8'sh00, 1'b0, 8'sh00},
      '{REQ_INFLATE, 6'd63, 6'd63, 6'd63, 8'shff, 1'b0, 8'sh00},
      '{REQ_READ,    6'd21, 6'd42, 6'd0,  8'sh00, 1'b0, 8'sh00},
      '{REQ_READ,    6'd0,  6'd0,  6'd0,  8'sh00, 1'b0, 8'sh00}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].z, directed_rows[i].voxel,
                   directed_rows[i].typed, directed_rows[i].want);

    // backpressure: the receiver holds off while reads keep coming, so one
    // result sits on the output and the request side stalls behind it
    rx_hold_left = HOLD_TICKS;
    for (int n = 0; n < 10; n++) begin
      pick_written_cell(x, y, z);
      send_request(REQ_READ, x, y, z, 8'($urandom));
    end
    // sender waits for every outstanding read before going on
    wait_reads_drained();

    run_phase(1,  5,   5,   5,   40, 1'b0);
    run_phase(15, 4,   4,   4,   40, 1'b0);   // most passes
    run_phase(3,  127, 3,   3,   40, 1'b0);   // x extent clipped to storage
    run_phase(15, 1,   127, 127, 40, 1'b0);   // no interior, y and z clipped
    run_phase(0,  7,   6,   5,   40, 1'b1);   // zero passes, no idle cycles
    run_phase(2,  5,   6,   7,   40, 1'b0);
    run_phase(1,  3,   3,   3,   40, 1'b0);   // single interior voxel
    run_phase(4,  2,   3,   64,  40, 1'b0);   // extent of 2, nothing to dilate
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(0, 4), $urandom_range(1, 6), $urandom_range(1, 6),
                $urandom_range(1, 6), 40, $urandom_range(0, 3) == 0);

    wait_reads_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (pending_reads.size() != 0)
      note_mismatch($sformatf("%0d reads never answered", pending_reads.size()));

    $display("sent %0d requests (%0d inflates) over %0d register settings",
             requests_sent, inflates_sent, phases_run + 1);
    $display("compared %0d voxel reads, %0d mismatches", reads_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("voxel_map_dilation_unit_test passed");
    end else begin
      $display("voxel_map_dilation_unit_test failed");
    end
    $finish;
  end

endmodule
